// ----- rtl/priority_ordered_queue_unit_assert.svh -----
// ------------------------------------------------------------------------
// priority ordered queue assertion macros
// shared property forms for the queue checker
// ------------------------------------------------------------------------
`ifndef PRIORITY_ORDERED_QUEUE_UNIT_ASSERT_SVH
`define PRIORITY_ORDERED_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication, quiet while reset is high
`define POQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet while reset is high
`define POQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/poq_pkg.sv -----
// ------------------------------------------------------------------------
// poq_pkg
// shared types and constants of the priority ordered queue
// ------------------------------------------------------------------------
package poq_pkg;

   localparam int DEPTH     = 16;
   localparam int TOP_LEVEL = 3;
   localparam int LEVEL_W   = 2;
   localparam int AGE_W     = 7;
   localparam int HANDLE_W  = 32;
   localparam int OCC_W     = 5;
   localparam int CNT_W     = $clog2(DEPTH + 1);

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_FULL     = 2'd2,
      ST_BADLEVEL = 2'd3
   } status_type;

   typedef struct packed {
      logic [LEVEL_W-1:0]  level;
      logic [AGE_W-1:0]    age;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

   // broadcast to every cell each cycle
   typedef struct packed {
      logic      insert_en;
      logic      remove_en;
      entry_type new_entry;
   } cell_ctrl_type;

endpackage

// ----- rtl/poq_cell.sv -----
// ------------------------------------------------------------------------
// poq_cell
// one slot of the sorted queue: holds an entry, shifts left or right
// ------------------------------------------------------------------------
module poq_cell (
   input  logic                   clock,
   input  poq_pkg::cell_ctrl_type ctrl,
   input  logic                   occupied,
   input  logic                   left_ge,
   input  poq_pkg::entry_type     left_entry,
   input  poq_pkg::entry_type     right_entry,
   output poq_pkg::entry_type     entry,
   output logic                   ge
);

   poq_pkg::entry_type entry_ff;
   poq_pkg::entry_type entry_in;

   // entries of equal or higher level stay ahead of a new one
   assign ge    = occupied && (entry_ff.level >= ctrl.new_entry.level);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert_en && !ge) begin
         // first cell below the boundary takes the new entry, the rest shift down
         entry_in = left_ge ? ctrl.new_entry : left_entry;
      end else if (ctrl.remove_en) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ----- rtl/priority_ordered_queue_unit.sv -----
// ------------------------------------------------------------------------
// priority_ordered_queue_unit
// sorted priority queue built as a chain of entry cells
// ------------------------------------------------------------------------
// result: registered, valid in the cycle after the request beat is accepted
// throughput: one item per cycle unless a result beat is stalled; every cell
//    compares its level with the incoming one in parallel and shifts in the same cycle
// reset: clears the entry count and the result valid; cell contents are
//    left undefined and are never read before being written
module priority_ordered_queue_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_kind,
   input  logic [poq_pkg::LEVEL_W-1:0]  req_level,
   input  logic [poq_pkg::AGE_W-1:0]    req_age,
   input  logic [poq_pkg::HANDLE_W-1:0] req_record_handle,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_status,
   output logic [poq_pkg::LEVEL_W-1:0]  rsp_out_level,
   output logic [poq_pkg::AGE_W-1:0]    rsp_out_age,
   output logic [poq_pkg::HANDLE_W-1:0] rsp_out_handle,
   output logic [poq_pkg::OCC_W-1:0]    rsp_occupancy
);

   logic [poq_pkg::CNT_W-1:0] count_ff;
   logic [poq_pkg::CNT_W-1:0] count_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   poq_pkg::status_type       rsp_status_ff;
   poq_pkg::status_type       rsp_status_in;
   poq_pkg::entry_type        rsp_entry_ff;
   poq_pkg::entry_type        rsp_entry_in;
   logic [poq_pkg::OCC_W-1:0] rsp_occ_ff;
   logic [poq_pkg::OCC_W-1:0] rsp_occ_in;

   poq_pkg::cell_ctrl_type    ctrl;
   poq_pkg::entry_type        cell_entry  [poq_pkg::DEPTH];
   logic                      cell_ge     [poq_pkg::DEPTH];
   logic                      cell_occ    [poq_pkg::DEPTH];
   logic                      left_ge     [poq_pkg::DEPTH];
   poq_pkg::entry_type        left_entry  [poq_pkg::DEPTH];
   poq_pkg::entry_type        right_entry [poq_pkg::DEPTH];

   logic accept;
   logic bad_level;
   logic is_full;
   logic is_empty;
   logic do_insert;
   logic do_remove;

   // output register frees up when its beat is taken
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign bad_level = (req_level == '0) ||
                      (req_level > poq_pkg::LEVEL_W'(poq_pkg::TOP_LEVEL));
   assign is_full   = (count_ff == poq_pkg::CNT_W'(poq_pkg::DEPTH));
   assign is_empty  = (count_ff == '0);
   assign do_insert = accept && (req_kind == poq_pkg::KIND_INSERT) && !bad_level && !is_full;
   assign do_remove = accept && (req_kind == poq_pkg::KIND_REMOVE) && !is_empty;

   assign ctrl.insert_en        = do_insert;
   assign ctrl.remove_en        = do_remove;
   assign ctrl.new_entry.level  = req_level;
   assign ctrl.new_entry.age    = req_age;
   assign ctrl.new_entry.handle = req_record_handle;

   for (genvar i = 0; i < poq_pkg::DEPTH; i++) begin : g_cell
      assign cell_occ[i] = (poq_pkg::CNT_W'(i) < count_ff);

      if (i == 0) begin : g_head
         assign left_ge[i]    = 1'b1;
         assign left_entry[i] = ctrl.new_entry;
      end else begin : g_body
         assign left_ge[i]    = cell_ge[i-1];
         assign left_entry[i] = cell_entry[i-1];
      end

      if (i == poq_pkg::DEPTH - 1) begin : g_tail
         assign right_entry[i] = cell_entry[i];
      end else begin : g_inner
         assign right_entry[i] = cell_entry[i+1];
      end

      poq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (cell_occ[i]),
         .left_ge     (left_ge[i]),
         .left_entry  (left_entry[i]),
         .right_entry (right_entry[i]),
         .entry       (cell_entry[i]),
         .ge          (cell_ge[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (do_insert) begin
         count_in = count_ff + poq_pkg::CNT_W'(1);
      end else if (do_remove) begin
         count_in = count_ff - poq_pkg::CNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_occ_in    = rsp_occ_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_entry_in = '0;
         rsp_occ_in   = poq_pkg::OCC_W'(count_in);
         if (req_kind == poq_pkg::KIND_REMOVE) begin
            if (is_empty) begin
               rsp_status_in = poq_pkg::ST_EMPTY;
            end else begin
               rsp_status_in = poq_pkg::ST_DONE;
               rsp_entry_in  = cell_entry[0];
            end
         end else if (bad_level) begin
            rsp_status_in = poq_pkg::ST_BADLEVEL;
         end else if (is_full) begin
            rsp_status_in = poq_pkg::ST_FULL;
         end else begin
            rsp_status_in = poq_pkg::ST_DONE;
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_level  = rsp_entry_ff.level;
   assign rsp_out_age    = rsp_entry_ff.age;
   assign rsp_out_handle = rsp_entry_ff.handle;
   assign rsp_occupancy  = rsp_occ_ff;

endmodule

// ----- rtl/poq_checker.sv -----
// ------------------------------------------------------------------------
// poq_checker
// port-level checks of the priority ordered queue, bound to the top level
// ------------------------------------------------------------------------
`include "priority_ordered_queue_unit_assert.svh"

module poq_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [1:0]                   rsp_status,
   input logic [poq_pkg::LEVEL_W-1:0]  rsp_out_level,
   input logic [poq_pkg::AGE_W-1:0]    rsp_out_age,
   input logic [poq_pkg::HANDLE_W-1:0] rsp_out_handle,
   input logic [poq_pkg::OCC_W-1:0]    rsp_occupancy
);

   // a stalled result beat holds
   `POQ_ASSERT_NEXT(a_rsp_hold,
      rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_status) && $stable(rsp_out_level) &&
         $stable(rsp_out_age) && $stable(rsp_out_handle) && $stable(rsp_occupancy),
      "stalled result beat changed")

   // every accepted request beat yields a result beat next cycle
   `POQ_ASSERT_NEXT(a_req_to_rsp,
      req_valid && !req_stall,
      rsp_valid,
      "accepted request gave no result")

   // only a completed remove carries an entry
   `POQ_ASSERT_NOW(a_empty_fields,
      rsp_valid && (rsp_status != poq_pkg::ST_DONE),
      (rsp_out_level == '0) && (rsp_out_age == '0) && (rsp_out_handle == '0),
      "rejected item carried an entry")

   `POQ_ASSERT_NOW(a_empty_occ,
      rsp_valid && (rsp_status == poq_pkg::ST_EMPTY),
      rsp_occupancy == '0,
      "empty status with entries held")

   `POQ_ASSERT_NOW(a_full_occ,
      rsp_valid && (rsp_status == poq_pkg::ST_FULL),
      rsp_occupancy == poq_pkg::OCC_W'(poq_pkg::DEPTH),
      "full status below capacity")

endmodule

bind priority_ordered_queue_unit poq_checker u_poq_checker (.*);
